### design/mfbd_pkg.sv
// Shared definitions for the message FIFO with bulk drain.
// Holds the action codes, configuration register indexes and byte-mask helpers.
// No dependencies.
package mfbd_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH    = 2'd0,
    ACT_POP     = 2'd1,
    ACT_FLUSH   = 2'd2,
    ACT_EXTRACT = 2'd3
  } action_t;

  localparam logic CFG_DEPTH_IN_USE = 1'b0;
  localparam logic CFG_ENTRY_BYTES  = 1'b1;

  function automatic logic [63:0] mask_lo(input logic [4:0] n);
    if (n >= 5'd8) return '1;
    return (64'd1 << (8'(n) << 3)) - 64'd1;
  endfunction

  function automatic logic [63:0] mask_hi(input logic [4:0] n);
    if (n <= 5'd8) return '0;
    if (n >= 5'd16) return '1;
    return (64'd1 << ((8'(n) - 8'd8) << 3)) - 64'd1;
  endfunction

endpackage

### design/message_fifo_with_bulk_drain_unit.sv
// Top level of the message FIFO with bulk drain: ring-addressed entry memory,
// action sequencer, result registers and configuration registers.
// Depends on mfbd_pkg.
//
// Usage: an item is taken at a rising edge where start is high and busy is low.
// Its action is push, pop, flush or extract. Every item produces at least one
// result, shown for one cycle with out_valid high; out_last marks the final
// result of an item. The receiver cannot stall, so results are never held. Push
// and pop give one result, and busy stays low, so one push or pop item is taken
// per cycle. Flush and extract of N entries take the first entry at acceptance
// and one more per cycle, giving N results on consecutive cycles; busy stays
// high until the last entry is taken. The single read port of the entry memory
// sets this drain rate. Refused or empty actions give a single result with
// out_data_valid low. Configuration is written through cfg_we, cfg_index and
// cfg_wdata; the user must write it only while idle, which the block does not
// enforce. Reset clears the pointers, the entry count and the result strobe,
// and sets depth_in_use to 64 and entry_bytes to 16. Memory contents need no
// clearing, since only entries written by a push are ever read back.
module message_fifo_with_bulk_drain_unit #(
  parameter int MAX_DEPTH       = 64,
  parameter int ENTRY_BYTES_MAX = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mfbd_pkg::action_t   in_action,
  input  logic [63:0]         in_data_low,
  input  logic [63:0]         in_data_high,
  input  logic [4:0]          in_byte_length,
  input  logic [6:0]          in_item_count,
  output logic                out_valid,
  output logic [63:0]         out_low,
  output logic [63:0]         out_high,
  output logic                out_data_valid,
  output logic                out_accepted,
  output logic                out_last,
  output logic [6:0]          out_entries_held,
  output logic                out_full_res,
  output logic                out_empty_res,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_wdata
);
  import mfbd_pkg::*;

  localparam int AW = $clog2(MAX_DEPTH);
  localparam int CW = $clog2(MAX_DEPTH + 1);
  localparam int DW = (CW > 7) ? CW : 7;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  logic [127:0]  store_mem [MAX_DEPTH];
  logic [127:0]  rd_data_r;

  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [6:0]    depth_r;
  logic [4:0]    ebytes_r;

  logic          ov_r, ov_nxt;
  logic          odv_r, odv_nxt;
  logic          oacc_r, oacc_nxt;
  logic          olast_r, olast_nxt;
  logic [6:0]    ocnt_r, ocnt_nxt;
  logic          ofull_r, ofull_nxt;
  logic          oempty_r, oempty_nxt;
  logic [4:0]    olen_r, olen_nxt;

  logic          accept;
  logic [4:0]    eff_width;
  logic [DW-1:0] eff_depth;
  logic          push_ok, pop_ok, drain_go, take;
  logic [CW-1:0] drain_n;
  logic [DW-1:0] held_nxt_ext;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign eff_width = (ebytes_r > 5'(ENTRY_BYTES_MAX)) ? 5'(ENTRY_BYTES_MAX) : ebytes_r;
  assign eff_depth = (DW'(depth_r) > DW'(MAX_DEPTH)) ? DW'(MAX_DEPTH) : DW'(depth_r);

  always_comb begin
    push_ok   = 1'b0;
    pop_ok    = 1'b0;
    drain_go  = 1'b0;
    drain_n   = '0;
    state_nxt = state_r;
    rem_nxt   = rem_r;
    ov_nxt    = 1'b0;
    odv_nxt   = 1'b0;
    oacc_nxt  = 1'b0;
    olast_nxt = 1'b1;
    olen_nxt  = olen_r;

    if (state_r == ST_DRAIN) begin
      ov_nxt    = 1'b1;
      odv_nxt   = 1'b1;
      oacc_nxt  = 1'b1;
      olast_nxt = (rem_r == CW'(1));
      olen_nxt  = eff_width;
      rem_nxt   = rem_r - CW'(1);
      if (rem_r == CW'(1)) state_nxt = ST_IDLE;
    end else if (accept) begin
      ov_nxt = 1'b1;
      case (in_action)
        ACT_PUSH: begin
          push_ok  = (DW'(held_r) < eff_depth) && (in_byte_length != 5'd0) &&
                     (in_byte_length <= eff_width);
          oacc_nxt = push_ok;
        end
        ACT_POP: begin
          pop_ok   = (held_r != '0) && (in_byte_length != 5'd0) &&
                     (in_byte_length <= eff_width);
          oacc_nxt = pop_ok;
          odv_nxt  = pop_ok;
          olen_nxt = in_byte_length;
        end
        ACT_FLUSH: begin
          oacc_nxt = 1'b1;
          if (held_r != '0) begin
            drain_go = 1'b1;
            drain_n  = held_r;
          end
        end
        ACT_EXTRACT: begin
          if (in_item_count == 7'd0) begin
            oacc_nxt = 1'b1;
          end else if (DW'(held_r) >= DW'(in_item_count)) begin
            oacc_nxt = 1'b1;
            drain_go = 1'b1;
            drain_n  = CW'(in_item_count);
          end
        end
        default: begin
          oacc_nxt = 1'b0;
        end
      endcase
      if (drain_go) begin
        odv_nxt   = 1'b1;
        olast_nxt = (drain_n == CW'(1));
        olen_nxt  = eff_width;
        rem_nxt   = drain_n - CW'(1);
        if (drain_n != CW'(1)) state_nxt = ST_DRAIN;
      end
    end

    take = pop_ok || drain_go || (state_r == ST_DRAIN);

    head_nxt = head_r;
    if (take) head_nxt = (head_r == AW'(MAX_DEPTH - 1)) ? '0 : head_r + AW'(1);
    tail_nxt = tail_r;
    if (push_ok) tail_nxt = (tail_r == AW'(MAX_DEPTH - 1)) ? '0 : tail_r + AW'(1);

    held_nxt = held_r;
    if (push_ok) held_nxt = held_r + CW'(1);
    else if (take) held_nxt = held_r - CW'(1);

    held_nxt_ext = DW'(held_nxt);
    ocnt_nxt     = held_nxt_ext[6:0];
    ofull_nxt    = (held_nxt_ext >= eff_depth);
    oempty_nxt   = (held_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      store_mem[tail_r] <= {in_data_high & mask_hi(in_byte_length),
                            in_data_low & mask_lo(in_byte_length)};
    end
    rd_data_r <= store_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      held_r   <= '0;
      rem_r    <= '0;
      depth_r  <= 7'd64;
      ebytes_r <= 5'd16;
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      held_r  <= held_nxt;
      rem_r   <= rem_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_DEPTH_IN_USE) depth_r <= cfg_wdata;
        if (cfg_index == CFG_ENTRY_BYTES) ebytes_r <= cfg_wdata[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    odv_r    <= odv_nxt;
    oacc_r   <= oacc_nxt;
    olast_r  <= olast_nxt;
    ocnt_r   <= ocnt_nxt;
    ofull_r  <= ofull_nxt;
    oempty_r <= oempty_nxt;
    olen_r   <= olen_nxt;
  end

  assign out_valid        = ov_r;
  assign out_low          = odv_r ? (rd_data_r[63:0] & mask_lo(olen_r)) : '0;
  assign out_high         = odv_r ? (rd_data_r[127:64] & mask_hi(olen_r)) : '0;
  assign out_data_valid   = odv_r;
  assign out_accepted     = oacc_r;
  assign out_last         = olast_r;
  assign out_entries_held = ocnt_r;
  assign out_full_res     = ofull_r;
  assign out_empty_res    = oempty_r;

  logic [AW:0] ring_sum;
  logic [AW:0] ring_tail;
  assign ring_sum  = (AW + 1)'(head_r) + (AW + 1)'(held_r);
  assign ring_tail = (ring_sum >= (AW + 1)'(MAX_DEPTH)) ?
                     ring_sum - (AW + 1)'(MAX_DEPTH) : ring_sum;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    DW'(held_r) <= DW'(MAX_DEPTH))
    else $error("entry count exceeds the memory depth");

  a_ring: assert property (@(posedge clk) disable iff (!rst_n)
    ring_tail[AW-1:0] == tail_r)
    else $error("tail pointer does not match head plus count");

  a_drain_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (rem_r != '0) && (DW'(rem_r) <= DW'(held_r)))
    else $error("drain asks for more entries than are held");

  a_mid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !olast_r) |-> (state_r == ST_DRAIN))
    else $error("non-final result outside a drain");

  a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(state_r == ST_DRAIN) && (state_r == ST_IDLE)) |->
    (ov_r && olast_r))
    else $error("drain ended without a final result");

endmodule

### verif/message_fifo_with_bulk_drain_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for message_fifo_with_bulk_drain_unit: directed and random
// push, pop, flush and extract items are checked against a queue model kept in the bench.
// Depends on mfbd_pkg and the unit itself; needs no files or arguments.
module message_fifo_with_bulk_drain_unit_test;
  import mfbd_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int WIDTH_MAX = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [63:0] low;
    logic [63:0] high;
    logic        data_valid;
    logic        accepted;
    logic        last;
    logic [6:0]  entries;
    logic        full;
    logic        empty;
  } fifo_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  action_t     in_action = ACT_PUSH;
  logic [63:0] in_data_low = '0;
  logic [63:0] in_data_high = '0;
  logic [4:0]  in_byte_length = '0;
  logic [6:0]  in_item_count = '0;
  logic        out_valid;
  logic [63:0] out_low;
  logic [63:0] out_high;
  logic        out_data_valid;
  logic        out_accepted;
  logic        out_last;
  logic [6:0]  out_entries_held;
  logic        out_full_res;
  logic        out_empty_res;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_DEPTH_IN_USE;
  logic [6:0]  cfg_wdata = '0;

  logic [127:0] msg_store [STORE_DEPTH];
  int unsigned  head_slot;
  int unsigned  held_entries;
  logic [6:0]   depth_reg;
  logic [4:0]   width_reg;
  fifo_result_t expected_results [$];
  fifo_result_t next_expected;
  int           mismatches = 0;
  int           send_idle_pct = 0;
  int           stall_cycles = 0;

  message_fifo_with_bulk_drain_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_data_low(in_data_low), .in_data_high(in_data_high),
    .in_byte_length(in_byte_length), .in_item_count(in_item_count),
    .out_valid(out_valid), .out_low(out_low), .out_high(out_high),
    .out_data_valid(out_data_valid), .out_accepted(out_accepted), .out_last(out_last),
    .out_entries_held(out_entries_held), .out_full_res(out_full_res),
    .out_empty_res(out_empty_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned depth_limit();
    return (depth_reg > STORE_DEPTH) ? STORE_DEPTH : depth_reg;
  endfunction

  function automatic int unsigned width_limit();
    return (width_reg > WIDTH_MAX) ? WIDTH_MAX : width_reg;
  endfunction

  function automatic logic [127:0] byte_mask(int unsigned n);
    if (n == 0) return '0;
    if (n >= WIDTH_MAX) return '1;
    return ~({128{1'b1}} << (8 * n));
  endfunction

  function automatic void post_result(logic [127:0] data, logic data_valid, logic accepted,
                                     logic last);
    fifo_result_t r;
    r.low = data[63:0];
    r.high = data[127:64];
    r.data_valid = data_valid;
    r.accepted = accepted;
    r.last = last;
    r.entries = 7'(held_entries);
    r.full = (held_entries >= depth_limit());
    r.empty = (held_entries == 0);
    expected_results.push_back(r);
  endfunction

  function automatic logic [127:0] take_oldest(int unsigned n);
    logic [127:0] data;
    data = msg_store[head_slot] & byte_mask(n);
    msg_store[head_slot] = '0;
    head_slot = (head_slot + 1) % STORE_DEPTH;
    held_entries--;
    return data;
  endfunction

  function automatic void apply_action(action_t act, logic [127:0] data, logic [4:0] len,
                                       logic [6:0] cnt);
    int unsigned w;
    logic [127:0] entry;
    w = width_limit();
    case (act)
      ACT_PUSH: begin
        if (held_entries < depth_limit() && len != 0 && len <= w) begin
          msg_store[(head_slot + held_entries) % STORE_DEPTH] = data & byte_mask(len);
          held_entries++;
          post_result('0, 1'b0, 1'b1, 1'b1);
        end else begin
          post_result('0, 1'b0, 1'b0, 1'b1);
        end
      end
      ACT_POP: begin
        if (held_entries != 0 && len != 0 && len <= w) begin
          entry = take_oldest(len);
          post_result(entry, 1'b1, 1'b1, 1'b1);
        end else begin
          post_result('0, 1'b0, 1'b0, 1'b1);
        end
      end
      ACT_FLUSH: begin
        if (held_entries == 0) post_result('0, 1'b0, 1'b1, 1'b1);
        while (held_entries != 0) begin
          entry = take_oldest(w);
          post_result(entry, 1'b1, 1'b1, held_entries == 0);
        end
      end
      ACT_EXTRACT: begin
        if (cnt == 0) begin
          post_result('0, 1'b0, 1'b1, 1'b1);
        end else if (held_entries < cnt) begin
          post_result('0, 1'b0, 1'b0, 1'b1);
        end else begin
          for (int k = 1; k <= cnt; k++) begin
            entry = take_oldest(w);
            post_result(entry, 1'b1, 1'b1, k == cnt);
          end
        end
      end
      default: begin
        post_result('0, 1'b0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  task automatic issue_item(input action_t act, input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] len, input logic [6:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_data_low <= lo;
    in_data_high <= hi;
    in_byte_length <= len;
    in_item_count <= cnt;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_action(act, {hi, lo}, len, cnt);
  endtask

  task automatic write_config(input logic [6:0] depth_word, input logic [6:0] bytes_word);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DEPTH_IN_USE;
    cfg_wdata <= depth_word;
    @(posedge clk);
    cfg_index <= CFG_ENTRY_BYTES;
    cfg_wdata <= bytes_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    depth_reg = depth_word;
    width_reg = bytes_word[4:0];
  endtask

  task automatic test_basic_actions();
    issue_item(ACT_POP, '0, '0, 5'd16, 7'd0);
    issue_item(ACT_FLUSH, '0, '0, 5'd0, 7'd0);
    issue_item(ACT_EXTRACT, '0, '0, 5'd0, 7'd0);
    issue_item(ACT_EXTRACT, '0, '0, 5'd0, 7'd1);
    issue_item(ACT_PUSH, rand64(), rand64(), 5'd0, 7'd0);
    issue_item(ACT_PUSH, rand64(), rand64(), 5'd31, 7'd0);
    issue_item(ACT_PUSH, '1, '1, 5'd1, 7'd0);
    issue_item(ACT_PUSH, '1, '1, 5'd16, 7'd0);
    issue_item(ACT_PUSH, rand64(), rand64(), 5'd9, 7'd0);
    issue_item(ACT_POP, '0, '0, 5'd0, 7'd0);
    issue_item(ACT_POP, '0, '0, 5'd17, 7'd0);
    issue_item(ACT_POP, '0, '0, 5'd16, 7'd0);
    issue_item(ACT_POP, '0, '0, 5'd1, 7'd0);
    issue_item(ACT_PUSH, rand64(), rand64(), 5'd8, 7'd0);
    issue_item(ACT_EXTRACT, '0, '0, 5'd0, 7'd3);
    issue_item(ACT_EXTRACT, '0, '0, 5'd0, 7'd2);
  endtask

  task automatic test_register_extremes();
    write_config(7'd1, 7'd1);
    issue_item(ACT_PUSH, rand64(), rand64(), 5'd1, 7'd0);
    issue_item(ACT_PUSH, rand64(), rand64(), 5'd1, 7'd0);
    issue_item(ACT_POP, '0, '0, 5'd2, 7'd0);
    issue_item(ACT_POP, '0, '0, 5'd1, 7'd0);
    write_config(7'd64, 7'd16);
    issue_item(ACT_PUSH, rand64(), rand64(), 5'd16, 7'd0);
    issue_item(ACT_PUSH, rand64(), rand64(), 5'd16, 7'd0);
    issue_item(ACT_PUSH, rand64(), rand64(), 5'd12, 7'd0);
    // Both registers at zero while three entries are still held.
    write_config(7'd0, 7'd0);
    issue_item(ACT_PUSH, rand64(), rand64(), 5'd1, 7'd0);
    issue_item(ACT_POP, '0, '0, 5'd1, 7'd0);
    issue_item(ACT_EXTRACT, '0, '0, 5'd0, 7'd1);
    issue_item(ACT_FLUSH, '0, '0, 5'd0, 7'd0);
    write_config(7'd127, 7'd127);
    issue_item(ACT_PUSH, rand64(), rand64(), 5'd16, 7'd0);
    issue_item(ACT_PUSH, rand64(), rand64(), 5'd17, 7'd0);
    issue_item(ACT_POP, '0, '0, 5'd16, 7'd0);
  endtask

  task automatic test_random_traffic(input int items, input int idle_pct);
    int unsigned pick;
    logic [4:0] len;
    logic [6:0] cnt;
    send_idle_pct = idle_pct;
    for (int i = 0; i < items; i++) begin
      if (i % 20 == 0) begin
        write_config(($urandom_range(1) == 0) ? 7'($urandom_range(8, 1))
                                               : 7'($urandom_range(STORE_DEPTH, 9)),
                     {2'($urandom), 5'($urandom_range(WIDTH_MAX, 1))});
      end
      pick = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(width_limit(), 1));
      cnt = (held_entries != 0) ? 7'($urandom_range(held_entries, 0)) : 7'd0;
      if (pick < 45) begin
        issue_item(ACT_PUSH, rand64(), rand64(), len, 7'($urandom));
      end else if (pick < 75) begin
        issue_item(ACT_POP, rand64(), rand64(), len, 7'($urandom));
      end else if (pick < 85) begin
        issue_item(ACT_EXTRACT, rand64(), rand64(), 5'($urandom), cnt);
      end else if (pick < 90) begin
        issue_item(ACT_FLUSH, rand64(), rand64(), 5'($urandom), 7'($urandom));
      end else begin
        issue_item(action_t'($urandom_range(3)), rand64(), rand64(), 5'($urandom),
                   7'($urandom));
      end
    end
  endtask

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual low %h high %h",
                   $time, out_low, out_high);
      end else begin
        next_expected = expected_results.pop_front();
        compare_field("out_low", next_expected.low, out_low);
        compare_field("out_high", next_expected.high, out_high);
        compare_field("out_data_valid", 64'(next_expected.data_valid), 64'(out_data_valid));
        compare_field("out_accepted", 64'(next_expected.accepted), 64'(out_accepted));
        compare_field("out_last", 64'(next_expected.last), 64'(out_last));
        compare_field("out_entries_held", 64'(next_expected.entries), 64'(out_entries_held));
        compare_field("out_full_res", 64'(next_expected.full), 64'(out_full_res));
        compare_field("out_empty_res", 64'(next_expected.empty), 64'(out_empty_res));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    depth_reg = 7'd64;
    width_reg = 5'd16;
    head_slot = 0;
    held_entries = 0;
    foreach (msg_store[i]) msg_store[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 6;
    test_basic_actions();
    test_register_extremes();
    test_random_traffic(30, 6);
    test_random_traffic(30, 70);
    test_random_traffic(20, 0);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
